// File: rtl/core/dhd_pkg.sv
// Shared types and constants for the detection head decoder.
// Used by every module in rtl/core; no dependencies of its own.
`timescale 1ns / 1ps

package dhd_pkg;

    localparam int VALUE_W     = 24;   // signed Q11.12 stream value
    localparam int THR_W       = 13;
    localparam int GAIN_W      = 24;   // unsigned Q8.16
    localparam int PAD_W       = 11;
    localparam int FRAME_W     = 13;
    localparam int PIX_W       = 13;
    localparam int SCORE_W     = 23;
    localparam int CLASS_W     = 8;
    localparam int POS_W       = 8;
    localparam int FRAC_W      = 12;
    localparam int COORDS      = 4;    // cx, cy, w, h ahead of the scores
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int FIFO_DEPTH  = 4;
    localparam int DEFAULT_MAX_CLASSES = 128;

    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 88;

    // Back-end datapath widths
    localparam int DIFF_W      = VALUE_W + 1;          // centre minus padding
    localparam int PROD_W      = DIFF_W + GAIN_W + 1;  // Q.28 products
    localparam int EDGE_W      = PROD_W + 2;           // Q.29 corners
    localparam int LOW_W       = FRAME_W + 29;         // bits that survive the output mask
    localparam int RND_SHIFT   = 29;

    localparam logic [POS_W-1:0] POS_SAT = '1;

    localparam logic [THR_W-1:0]   RST_THRESHOLD = 13'd1024;
    localparam logic [GAIN_W-1:0]  RST_GAIN      = 24'd65536;
    localparam logic [PAD_W-1:0]   RST_PAD       = '0;
    localparam logic [FRAME_W-1:0] RST_FRAME_W   = 13'd640;
    localparam logic [FRAME_W-1:0] RST_FRAME_H   = 13'd480;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SCORE_THRESHOLD = 3'd0,
        CFG_INVERSE_GAIN    = 3'd1,
        CFG_PAD_LEFT        = 3'd2,
        CFG_PAD_TOP         = 3'd3,
        CFG_FRAME_WIDTH     = 3'd4,
        CFG_FRAME_HEIGHT    = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [GAIN_W-1:0]  gain;
        logic [PAD_W-1:0]   pad_left;
        logic [PAD_W-1:0]   pad_top;
        logic [FRAME_W-1:0] frame_w;
        logic [FRAME_W-1:0] frame_h;
    } t_cfg;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [CLASS_W-1:0] cls;
        logic               overflow;
    } t_meta;

    typedef struct packed {
        logic signed [VALUE_W-1:0] cx;
        logic signed [VALUE_W-1:0] cy;
        logic signed [VALUE_W-1:0] w;
        logic signed [VALUE_W-1:0] h;
        t_meta                     meta;
    } t_job;

    typedef struct packed {
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] width;
        logic [PIX_W-1:0] height;
        t_meta            meta;
    } t_result;

endpackage

// File: rtl/core/dhd_front.sv
// Front end: takes stream values, latches the box coordinates and keeps the
// running class arg-max; queues a decode job for each anchor that passes.
// Depends on dhd_pkg.
`timescale 1ns / 1ps

module dhd_front #(
    parameter int MAX_CLASSES = dhd_pkg::DEFAULT_MAX_CLASSES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [dhd_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_last,
    input  logic [dhd_pkg::THR_W-1:0]           i_threshold,
    input  logic                                i_full,
    output logic                                o_push,
    output dhd_pkg::t_job                       o_job
);
    import dhd_pkg::*;

    localparam logic [POS_W:0] CLS_LIMIT = (POS_W + 1)'(MAX_CLASSES + COORDS);

    logic [POS_W-1:0]          r_pos;
    logic [SCORE_W-1:0]        r_best;
    logic [CLASS_W-1:0]        r_cls;
    logic                      r_ovf;
    logic signed [VALUE_W-1:0] r_cx, r_cy, r_w, r_h;

    logic [POS_W-1:0]   n_pos;
    logic [SCORE_W-1:0] n_best;
    logic [CLASS_W-1:0] n_cls;
    logic               n_ovf;
    logic               w_accept;
    logic               w_is_score;
    logic               w_past_max;
    logic               w_better;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_is_score = (r_pos >= POS_W'(COORDS));
        w_past_max = (r_pos == POS_SAT) || ({1'b0, r_pos} >= CLS_LIMIT);
        w_better   = !i_value[VALUE_W-1] && (i_value[SCORE_W-1:0] > r_best);
        n_best = r_best;
        n_cls  = r_cls;
        n_ovf  = r_ovf;
        if (w_is_score) begin
            if (w_past_max) begin
                n_ovf = 1'b1;
            end else if (w_better) begin
                n_best = i_value[SCORE_W-1:0];
                n_cls  = CLASS_W'(r_pos - POS_W'(COORDS));
            end
        end
        n_pos = (r_pos == POS_SAT) ? r_pos : r_pos + 1'b1;
    end

    // a job leaves only on the last value of a full anchor that clears the threshold
    assign o_push = w_accept && i_last && w_is_score
                 && (n_best >= SCORE_W'(i_threshold));

    always_comb begin
        o_job.cx            = r_cx;
        o_job.cy            = r_cy;
        o_job.w             = r_w;
        o_job.h             = r_h;
        o_job.meta.score    = n_best;
        o_job.meta.cls      = n_cls;
        o_job.meta.overflow = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_best <= '0;
            r_cls  <= '1;
            r_ovf  <= 1'b0;
        end else if (w_accept) begin
            if (i_last) begin
                r_pos  <= '0;
                r_best <= '0;
                r_cls  <= '1;
                r_ovf  <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_best <= n_best;
                r_cls  <= n_cls;
                r_ovf  <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            case (r_pos)
                8'd0:    r_cx <= i_value;
                8'd1:    r_cy <= i_value;
                8'd2:    r_w  <= i_value;
                8'd3:    r_h  <= i_value;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/dhd_fifo.sv
// Short job queue between the front end and the decode pipeline.
// Show-ahead read; depends on dhd_pkg for the job type and depth.
`timescale 1ns / 1ps

module dhd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dhd_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output dhd_pkg::t_job o_data,
    output logic          o_empty
);
    import dhd_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/dhd_back.sv
// Decode pipeline: padding removal, reciprocal-gain multiply, centre to
// corners, clip and round, both axes side by side. Depends on dhd_pkg.
`timescale 1ns / 1ps

module dhd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dhd_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_pop,
    input  dhd_pkg::t_job    i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output dhd_pkg::t_result o_result
);
    import dhd_pkg::*;

    localparam logic [LOW_W-1:0] HALF = LOW_W'(1) << (RND_SHIFT - 1);

    logic w_adv;

    // stage 1: centre minus padding
    logic                      r1_valid;
    logic signed [DIFF_W-1:0]  r1_diff [2];
    logic signed [VALUE_W-1:0] r1_size [2];
    t_meta                     r1_meta;
    // stage 2: Q.28 products
    logic                      r2_valid;
    logic signed [PROD_W-1:0]  r2_c [2];
    logic signed [PROD_W-1:0]  r2_s [2];
    t_meta                     r2_meta;
    // stage 3: Q.29 corners
    logic                      r3_valid;
    logic signed [EDGE_W-1:0]  r3_lo [2];
    logic signed [EDGE_W-1:0]  r3_hi [2];
    t_meta                     r3_meta;
    // stage 4: clipped corners
    logic                      r4_valid;
    logic signed [EDGE_W-1:0]  r4_a [2];
    logic signed [EDGE_W-1:0]  r4_b [2];
    t_meta                     r4_meta;
    // stage 5: non-empty test, start rounded, raw length
    logic                      r5_valid;
    logic                      r5_ne [2];
    logic [LOW_W-1:0]          r5_len [2];
    logic [LOW_W-1:0]          r5_start [2];
    t_meta                     r5_meta;
    // output register
    logic                      r_out_valid;
    t_result                   r_out;

    logic signed [GAIN_W:0]         w_gain;
    logic signed [PAD_W+FRAC_W+1:0] w_pad [2];
    logic signed [EDGE_W-1:0]       w_edge [2];
    logic signed [DIFF_W-1:0]       w_cent [2];
    logic signed [PROD_W-2:0]       w_sprod [2];
    logic signed [EDGE_W-1:0]       w_c2 [2];
    logic signed [EDGE_W-1:0]       w_sx [2];
    logic [LOW_W-1:0]               w_len_r [2];

    assign w_adv = !r_out_valid || i_ready;
    assign o_pop = w_adv && i_valid;

    assign w_gain    = $signed({1'b0, i_cfg.gain});
    assign w_pad[0]  = $signed({2'b00, i_cfg.pad_left, {FRAC_W{1'b0}}});
    assign w_pad[1]  = $signed({2'b00, i_cfg.pad_top,  {FRAC_W{1'b0}}});
    assign w_edge[0] = $signed({{(EDGE_W - FRAME_W - RND_SHIFT){1'b0}}, i_cfg.frame_w,
                                {RND_SHIFT{1'b0}}});
    assign w_edge[1] = $signed({{(EDGE_W - FRAME_W - RND_SHIFT){1'b0}}, i_cfg.frame_h,
                                {RND_SHIFT{1'b0}}});
    assign w_cent[0] = {i_job.cx[VALUE_W-1], i_job.cx};
    assign w_cent[1] = {i_job.cy[VALUE_W-1], i_job.cy};

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_sprod[k] = r1_size[k] * w_gain;
            w_c2[k]    = {r2_c[k][PROD_W-1], r2_c[k], 1'b0};
            w_sx[k]    = {{2{r2_s[k][PROD_W-1]}}, r2_s[k]};
            w_len_r[k] = r5_len[k] + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r_out_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_size[0] <= i_job.w;
            r1_size[1] <= i_job.h;
            r1_meta    <= i_job.meta;
            r2_meta    <= r1_meta;
            r3_meta    <= r2_meta;
            r4_meta    <= r3_meta;
            r5_meta    <= r4_meta;
            for (int k = 0; k < 2; k++) begin
                r1_diff[k]  <= w_cent[k] - w_pad[k];
                r2_c[k]     <= r1_diff[k] * w_gain;
                r2_s[k]     <= {w_sprod[k][PROD_W-2], w_sprod[k]};
                r3_lo[k]    <= w_c2[k] - w_sx[k];
                r3_hi[k]    <= w_c2[k] + w_sx[k];
                r4_a[k]     <= (r3_lo[k] > 0) ? r3_lo[k] : '0;
                r4_b[k]     <= (r3_hi[k] < w_edge[k]) ? r3_hi[k] : w_edge[k];
                // only the low bits matter after the 13-bit output mask
                r5_ne[k]    <= (r4_b[k] > r4_a[k]);
                r5_len[k]   <= r4_b[k][LOW_W-1:0] - r4_a[k][LOW_W-1:0];
                r5_start[k] <= r4_a[k][LOW_W-1:0] + HALF;
            end
            r_out.meta <= r5_meta;
            if (r5_ne[0] && r5_ne[1]) begin
                r_out.left   <= r5_start[0][LOW_W-1:RND_SHIFT];
                r_out.top    <= r5_start[1][LOW_W-1:RND_SHIFT];
                r_out.width  <= w_len_r[0][LOW_W-1:RND_SHIFT];
                r_out.height <= w_len_r[1][LOW_W-1:RND_SHIFT];
            end else begin
                r_out.left   <= '0;
                r_out.top    <= '0;
                r_out.width  <= '0;
                r_out.height <= '0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// File: rtl/core/detection_head_decode.sv
// Top level of the detection head decoder: configuration registers, front
// end, job queue and decode pipeline. Depends on dhd_pkg, dhd_front,
// dhd_fifo and dhd_back.
`timescale 1ns / 1ps

// Takes one prediction value per cycle: centre x, centre y, width, height,
// then one class score per value, tlast on the final score. Each anchor
// that reaches the score threshold yields one box result after the job queue and
// decode pipeline; anchors below threshold or with fewer than five values yield
// nothing. The front end never waits on the box arithmetic: passing anchors sit
// in a four-entry queue, and s_axis_tready falls only when that queue is full.
// The decode pipeline (a 25x25 and a 24x25 multiplier per axis) takes a new
// anchor every cycle unless the output stalls. The user must write configuration
// through the plain write port only while the block is idle; it is not enforced.
module detection_head_decode #(
    parameter int MAX_CLASSES = dhd_pkg::DEFAULT_MAX_CLASSES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // value[23:0]
    input  logic [dhd_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tlast,
    output logic                              o_s_axis_tready,
    // box_left[12:0], box_top[25:13], box_width[38:26], box_height[51:39],
    // class_score[74:52], best_class[82:75], class_overflow[83], zero[87:84]
    output logic [dhd_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic                              i_cfg_we,
    input  logic [dhd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [dhd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import dhd_pkg::*;

    t_cfg    r_cfg;
    t_job    w_push_job, w_pop_job;
    t_result w_result;
    logic    w_push, w_full, w_pop, w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.gain      <= RST_GAIN;
            r_cfg.pad_left  <= RST_PAD;
            r_cfg.pad_top   <= RST_PAD;
            r_cfg.frame_w   <= RST_FRAME_W;
            r_cfg.frame_h   <= RST_FRAME_H;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_SCORE_THRESHOLD: r_cfg.threshold <= i_cfg_wdata[THR_W-1:0];
                CFG_INVERSE_GAIN:    r_cfg.gain      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_PAD_LEFT:        r_cfg.pad_left  <= i_cfg_wdata[PAD_W-1:0];
                CFG_PAD_TOP:         r_cfg.pad_top   <= i_cfg_wdata[PAD_W-1:0];
                CFG_FRAME_WIDTH:     r_cfg.frame_w   <= i_cfg_wdata[FRAME_W-1:0];
                CFG_FRAME_HEIGHT:    r_cfg.frame_h   <= i_cfg_wdata[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    dhd_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_value     ($signed(i_s_axis_tdata[VALUE_W-1:0])),
        .i_last      (i_s_axis_tlast),
        .i_threshold (r_cfg.threshold),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    dhd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_empty (w_empty)
    );

    dhd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (!w_empty),
        .o_pop    (w_pop),
        .i_job    (w_pop_job),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    assign o_m_axis_tdata = {4'b0000, w_result.meta.overflow, w_result.meta.cls,
                             w_result.meta.score, w_result.height, w_result.width,
                             w_result.top, w_result.left};

    // the front end must never hand a job to a full queue
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from empty queue");

    // no class picked means the running best never left zero
    a_no_class_zero_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_result.meta.cls == '1)) |-> (w_result.meta.score == '0))
        else $error("score without class");

endmodule
